/* hw/rtl/jpel_pkg.sv */
// Shared types and constants for the joystick PIN entry lock.
// No dependencies; imported by every module of the block.
package jpel_pkg;

  localparam int unsigned SampleW  = 14;
  localparam int unsigned ThrW     = 14;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned AttW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  localparam logic [ThrW-1:0]  HighThrRst = 14'd15000;
  localparam logic [ThrW-1:0]  LowThrRst  = 14'd1000;
  localparam logic [CodeW-1:0] SecretRst  = 16'h4321;
  localparam logic [AttW-1:0]  MaxAttRst  = 4'd3;

  // result word bit positions
  localparam int unsigned OutModeLsb   = 0;
  localparam int unsigned OutEventLsb  = 3;
  localparam int unsigned OutUnlockBit = 28;
  localparam int unsigned OutLockBit   = 29;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_THR = 2'd0,
    CFG_LOW_THR  = 2'd1,
    CFG_SECRET   = 2'd2,
    CFG_MAX_ATT  = 2'd3
  } jpel_cfg_e;

  typedef enum logic [2:0] {
    MODE_ENTER   = 3'd0,
    MODE_CHECK   = 3'd1,
    MODE_SUCCESS = 3'd2,
    MODE_FAIL    = 3'd3,
    MODE_LOCKED  = 3'd4
  } jpel_mode_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_PRESS = 3'd5
  } jpel_event_e;

  typedef struct packed {
    logic            locked_out;
    logic            unlocked;
    logic [AttW-1:0] tries;
    logic [1:0]      cursor;
    logic [15:0]     digits;
    jpel_mode_e      mode;
  } jpel_entry_t;

endpackage

/* hw/rtl/joystick_pin_entry_lock_unit.sv */
// Joystick PIN entry lock, top level: config registers, input and result words.
// Depends on jpel_pkg, jpel_joy_sampler and jpel_entry_fsm.
//
// Takes one word per clock and gives one result word per input word, through
// the input register, then the result register. All state is updated
// in the single cycle between those registers, so words follow back to back; the
// result register decouples the output side, and s_axis_tready only drops while
// a result is stalled and the input register is full. A start word (tuser = 1)
// resets the entry session without sampling the joystick. Config writes take
// effect on the next clock and belong to idle periods.
module joystick_pin_entry_lock_unit import jpel_pkg::*; #(
  parameter int unsigned CodeDigits = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // button_pressed, x_sample, y_sample, pad
  input  logic [0:0]          s_axis_tuser,  // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // entry_state, joystick_event, digit_zero..digit_three, cursor_position,
  // tries_remaining, unlocked, locked_out, pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [ThrW-1:0]  high_thr_q, low_thr_q;
  logic [CodeW-1:0] secret_q;
  logic [AttW-1:0]  max_att_q;

  logic               in_vld_q;
  logic               in_kind_q, in_btn_q;
  logic [SampleW-1:0] in_x_q, in_y_q;

  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic        out_free, step, accept, poll_en, start_en;
  jpel_event_e ev;
  jpel_entry_t entry;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign poll_en       = step && !in_kind_q;
  assign start_en      = step && in_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= HighThrRst;
      low_thr_q  <= LowThrRst;
      secret_q   <= SecretRst;
      max_att_q  <= MaxAttRst;
    end else if (cfg_we_i) begin
      case (jpel_cfg_e'(cfg_index_i))
        CFG_HIGH_THR: high_thr_q <= cfg_wdata_i[ThrW-1:0];
        CFG_LOW_THR:  low_thr_q  <= cfg_wdata_i[ThrW-1:0];
        CFG_SECRET:   secret_q   <= cfg_wdata_i[CodeW-1:0];
        CFG_MAX_ATT:  max_att_q  <= cfg_wdata_i[AttW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= s_axis_tuser[0];
      in_btn_q  <= s_axis_tdata[0];
      in_x_q    <= s_axis_tdata[SampleW:1];
      in_y_q    <= s_axis_tdata[2*SampleW:SampleW+1];
    end
  end

  jpel_joy_sampler u_sampler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll_en_i  (poll_en),
    .button_i   (in_btn_q),
    .x_i        (in_x_q),
    .y_i        (in_y_q),
    .high_thr_i (high_thr_q),
    .low_thr_i  (low_thr_q),
    .event_o    (ev)
  );

  jpel_entry_fsm #(
    .CodeDigits (CodeDigits)
  ) u_entry (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll_en_i  (poll_en),
    .start_en_i (start_en),
    .event_i    (ev),
    .secret_i   (secret_q),
    .max_att_i  (max_att_q),
    .entry_o    (entry)
  );

  assign out_data_d = {2'b00, entry.locked_out, entry.unlocked, entry.tries,
                       entry.cursor, entry.digits, ev, entry.mode};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/jpel_joy_sampler.sv */
// Joystick sampler: button edge detect and direction classification.
// Depends on jpel_pkg.
module jpel_joy_sampler import jpel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               poll_en_i,
  input  logic               button_i,
  input  logic [SampleW-1:0] x_i,
  input  logic [SampleW-1:0] y_i,
  input  logic [ThrW-1:0]    high_thr_i,
  input  logic [ThrW-1:0]    low_thr_i,
  output jpel_event_e        event_o
);

  logic        btn_down_q, btn_down_d;
  jpel_event_e prev_dir_q, prev_dir_d;
  jpel_event_e dir;

  always_comb begin
    if (y_i > high_thr_i) begin
      dir = EV_UP;
    end else if (y_i < low_thr_i) begin
      dir = EV_DOWN;
    end else if (x_i > high_thr_i) begin
      dir = EV_RIGHT;
    end else if (x_i < low_thr_i) begin
      dir = EV_LEFT;
    end else begin
      dir = EV_NONE;
    end
  end

  always_comb begin
    event_o    = EV_NONE;
    btn_down_d = btn_down_q;
    prev_dir_d = prev_dir_q;
    if (poll_en_i) begin
      if (button_i && !btn_down_q) begin
        // new press: direction history left alone
        event_o    = EV_PRESS;
        btn_down_d = 1'b1;
      end else begin
        btn_down_d = button_i;
        prev_dir_d = dir;
        if (prev_dir_q == EV_NONE && dir != EV_NONE) begin
          event_o = dir;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_down_q <= 1'b0;
      prev_dir_q <= EV_NONE;
    end else begin
      btn_down_q <= btn_down_d;
      prev_dir_q <= prev_dir_d;
    end
  end

endmodule

/* hw/rtl/jpel_entry_fsm.sv */
// Entry state machine: digit editing, cursor, code check and attempt count.
// Depends on jpel_pkg.
module jpel_entry_fsm import jpel_pkg::*; #(
  parameter int unsigned CodeDigits = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             poll_en_i,
  input  logic             start_en_i,
  input  jpel_event_e      event_i,
  input  logic [CodeW-1:0] secret_i,
  input  logic [AttW-1:0]  max_att_i,
  output jpel_entry_t      entry_o
);

  localparam int unsigned CurW = (CodeDigits > 1) ? $clog2(CodeDigits) : 1;
  localparam int unsigned DigW = 4 * CodeDigits;
  localparam logic [CurW-1:0] CurMax = CurW'(CodeDigits - 1);

  jpel_mode_e      mode_q, mode_d;
  logic [DigW-1:0] digits_q, digits_d;
  logic [CurW-1:0] cursor_q, cursor_d;
  logic [AttW-1:0] tries_q, tries_d;

  logic [DigW-1:0] want;
  logic [3:0]      sel;
  logic [AttW-1:0] tries_dec;
  logic            unlocked, locked_out;

  // code digits beyond the fourth compare against zero
  assign want      = DigW'(secret_i);
  assign sel       = digits_q[{cursor_q, 2'b00} +: 4];
  assign tries_dec = (tries_q != '0) ? tries_q - AttW'(1) : '0;

  always_comb begin
    mode_d     = mode_q;
    digits_d   = digits_q;
    cursor_d   = cursor_q;
    tries_d    = tries_q;
    unlocked   = 1'b0;
    locked_out = 1'b0;
    if (start_en_i) begin
      mode_d   = MODE_ENTER;
      tries_d  = max_att_i;
      digits_d = '0;
      cursor_d = '0;
    end else if (poll_en_i) begin
      case (mode_q)
        MODE_ENTER: begin
          if (event_i == EV_LEFT && cursor_q != '0) begin
            cursor_d = cursor_q - CurW'(1);
          end else if (event_i == EV_RIGHT && cursor_q < CurMax) begin
            cursor_d = cursor_q + CurW'(1);
          end else if (event_i == EV_UP) begin
            digits_d[{cursor_q, 2'b00} +: 4] = (sel == 4'd9) ? 4'd0 : sel + 4'd1;
          end else if (event_i == EV_DOWN) begin
            digits_d[{cursor_q, 2'b00} +: 4] = (sel == 4'd0) ? 4'd9 : sel - 4'd1;
          end else if (event_i == EV_PRESS) begin
            mode_d = MODE_CHECK;
          end
        end
        MODE_CHECK: begin
          if (digits_q == want) begin
            mode_d = MODE_SUCCESS;
          end else begin
            tries_d = tries_dec;
            mode_d  = (tries_dec == '0) ? MODE_LOCKED : MODE_FAIL;
          end
        end
        MODE_SUCCESS: begin
          unlocked = 1'b1;
        end
        MODE_FAIL: begin
          digits_d = '0;
          cursor_d = '0;
          mode_d   = MODE_ENTER;
        end
        default: begin
          locked_out = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    entry_o.mode       = mode_d;
    entry_o.digits     = 16'(digits_d);
    entry_o.cursor     = 2'(cursor_d);
    entry_o.tries      = tries_d;
    entry_o.unlocked   = unlocked;
    entry_o.locked_out = locked_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ENTER;
      digits_q <= '0;
      cursor_q <= '0;
      tries_q  <= MaxAttRst;
    end else begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      cursor_q <= cursor_d;
      tries_q  <= tries_d;
    end
  end

endmodule

/* hw/rtl/jpel_checker.sv */
// Port-level checks for the joystick PIN entry lock result stream.
// Depends on jpel_pkg; bound to joystick_pin_entry_lock_unit below.
module jpel_checker import jpel_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_tvalid_i,
  input logic                m_tready_i,
  input logic [OutDataW-1:0] m_tdata_i
);

  logic [2:0] mode;
  logic [2:0] ev;

  assign mode = m_tdata_i[OutModeLsb +: 3];
  assign ev   = m_tdata_i[OutEventLsb +: 3];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result word changed while stalled");

  a_unlock_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[OutUnlockBit] |-> mode == MODE_SUCCESS && ev != EV_PRESS ||
      mode == MODE_SUCCESS)
    else $error("unlocked outside success state");

  a_lock_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[OutLockBit] |-> mode == MODE_LOCKED)
    else $error("locked_out outside locked state");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> !(m_tdata_i[OutUnlockBit] && m_tdata_i[OutLockBit]))
    else $error("unlocked and locked_out both set");

endmodule

bind joystick_pin_entry_lock_unit jpel_checker u_jpel_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);
